// File: design/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Field widths, status codes and register indexes of the buddy allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int FIELD_W  = 20;   // request, user and result address fields
    localparam int STATUS_W = 3;
    localparam int ORDER_W  = 5;
    localparam int HDR_W    = 5;
    localparam int LIMIT_W  = 9;
    localparam int CFG_W    = 9;
    localparam int PAGES_W  = 10;   // pages of one fresh block
    localparam int END_W    = 11;   // bump pointer plus pages

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NULL_FREE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd5;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_HEADER_BYTES = 1'b0;
    localparam logic CFG_HEAP_LIMIT   = 1'b1;

    localparam logic [HDR_W-1:0]   HDR_RESET   = 5'd8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

endpackage
`default_nettype wire

// File: design/buddy_block_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Power-of-two block allocator with one LIFO free list per order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one item: an allocate (size in
//   i_request_bytes) or a free (i_user_address). Output channel
//   (o_valid / i_ready) returns one result item per input item.
//   Items are handled one at a time by a sequencer around two single-port
//   synchronous memories: a link memory (free-list next pointers) and a tag
//   memory (allocated mark and order per minimum block).
//   Steps: an allocate passes decode and list search, then a pop state when
//   it recycles a listed block, then the split loop, one link write per
//   level, down to the granted order, then the done state; a free passes
//   decode, the free state and the done state. Zero size, too large, null,
//   misaligned and out-of-range frees are reported straight from decode;
//   out of memory from the search, a free of an unmarked block from the free state.
//   The next item can be accepted in the cycle after a result is loaded.
//   After reset the tag memory is swept clear, one entry a cycle, over all
//   2^(ADDR_BITS-MIN_ORDER) entries (32768 by default); o_ready stays low
//   until the sweep ends. Configuration writes are taken at any time.
//   A finished result waits in the output register while the receiver
//   stalls; the next item is accepted meanwhile, but cannot finish until the
//   output register is free.
// ----------------------------------------------------------------------------
module buddy_block_allocator_top #(
    parameter int ADDR_BITS    = 20,
    parameter int MIN_ORDER    = 5,
    parameter int MAX_ORDER    = 17,
    parameter int REFILL_ORDER = 12,
    parameter int PAGE_ORDER   = 12
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_index,
    input  wire logic [bba_pkg::CFG_W-1:0]       i_cfg_data,
    // input items
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_op,
    input  wire logic [bba_pkg::FIELD_W-1:0]     i_request_bytes,
    input  wire logic [bba_pkg::FIELD_W-1:0]     i_user_address,
    // result items
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [bba_pkg::FIELD_W-1:0]          o_result_address,
    output logic [bba_pkg::STATUS_W-1:0]         o_status,
    output logic [bba_pkg::ORDER_W-1:0]          o_granted_order
);

    localparam int AW = ADDR_BITS;
    localparam int IW = ADDR_BITS - MIN_ORDER;          // block index bits
    localparam int NL = MAX_ORDER - MIN_ORDER + 1;      // number of lists
    localparam int KW = (NL > 1) ? $clog2(NL) : 1;
    localparam int OW = bba_pkg::ORDER_W;
    localparam int TW = OW + 1;                         // mark plus order
    localparam int FRESH_BASE = (REFILL_ORDER < MAX_ORDER) ? REFILL_ORDER : MAX_ORDER;
    localparam longint SPACE_PAGES =
        (ADDR_BITS >= PAGE_ORDER) ? (64'd1 << (ADDR_BITS - PAGE_ORDER)) : 64'd0;
    localparam int FW = bba_pkg::FIELD_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_SPLIT = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [2:0]                  r_state;
    logic [bba_pkg::HDR_W-1:0]   r_hdr;
    logic [bba_pkg::LIMIT_W-1:0] r_limit;
    logic [bba_pkg::LIMIT_W-1:0] r_nfp;
    logic [NL-1:0]               r_nonempty;
    logic [IW-1:0]               r_head [NL];
    logic                        r_clr_busy;
    logic [IW-1:0]               r_clr_idx;

    logic                        r_op;
    logic [FW-1:0]               r_req;
    logic [FW-1:0]               r_ua;
    logic [OW-1:0]               r_ord;
    logic [OW-1:0]               r_src;
    logic [AW-1:0]               r_baddr;

    logic [FW-1:0]               r_res_addr;
    logic [bba_pkg::STATUS_W-1:0] r_res_stat;
    logic [OW-1:0]               r_res_ord;

    logic                        r_oval;
    logic [FW-1:0]               r_oaddr;
    logic [bba_pkg::STATUS_W-1:0] r_ostat;
    logic [OW-1:0]               r_oord;

    // memories
    logic [IW:0]   link_mem [2**IW];     // {next valid, next index}
    logic [TW-1:0] tag_mem  [2**IW];     // {allocated, order}
    logic [IW:0]   r_link_rd;
    logic [TW-1:0] r_tag_rd;

    // ------------------------------------------------------------------
    // Decode of an allocate: round request plus header up to an order
    // ------------------------------------------------------------------
    logic [FW:0]   total;
    logic [FW:0]   total_m1;
    logic [OW-1:0] msb;
    logic [OW-1:0] ord_c;

    always_comb begin
        total    = {1'b0, r_req} + (FW+1)'(r_hdr);
        total_m1 = total - (FW+1)'(1);
        msb      = '0;
        for (int i = 0; i <= FW; i++) begin
            if (total_m1[i]) msb = OW'(i);
        end
        ord_c = (total_m1 == '0) ? '0 : msb + OW'(1);
    end

    // ------------------------------------------------------------------
    // Decode of a free: recover the block address and check it
    // ------------------------------------------------------------------
    logic [FW:0]   diff_f;
    logic          bad_free;
    logic [AW-1:0] baddr_f;

    always_comb begin
        diff_f   = {1'b0, r_ua} - (FW+1)'(r_hdr);
        bad_free = diff_f[FW]
                   || (33'(diff_f[FW-1:0]) >= (33'd1 << ADDR_BITS))
                   || (diff_f[MIN_ORDER-1:0] != '0);
        baddr_f  = AW'(diff_f[FW-1:0]);
    end

    // ------------------------------------------------------------------
    // List search and fresh block sizing
    // ------------------------------------------------------------------
    logic [KW-1:0]               ord_k;
    logic [NL-1:0]               srch_mask;
    logic                        found;
    logic [KW-1:0]               src_k;
    logic [OW-1:0]               fresh_ord;
    logic [bba_pkg::PAGES_W-1:0] pages;
    logic [bba_pkg::END_W-1:0]   end_pg;
    logic                        oom;

    always_comb begin
        ord_k     = KW'(r_ord - OW'(MIN_ORDER));
        srch_mask = r_nonempty & ({NL{1'b1}} << ord_k);
        found     = |srch_mask;
        src_k     = '0;
        for (int i = NL - 1; i >= 0; i--) begin
            if (srch_mask[i]) src_k = KW'(i);
        end
        fresh_ord = (r_ord > OW'(FRESH_BASE)) ? r_ord : OW'(FRESH_BASE);
        pages     = (fresh_ord >= OW'(PAGE_ORDER))
                    ? (bba_pkg::PAGES_W'(1) << (fresh_ord - OW'(PAGE_ORDER)))
                    : bba_pkg::PAGES_W'(1);
        end_pg    = bba_pkg::END_W'(r_nfp) + bba_pkg::END_W'(pages);
        oom       = (end_pg > bba_pkg::END_W'(r_limit))
                    || (64'(end_pg) > SPACE_PAGES);
    end

    // ------------------------------------------------------------------
    // Push onto a list: from a split level or from a free
    // ------------------------------------------------------------------
    logic [AW-1:0] upper_half;
    logic [OW-1:0] free_ord;
    logic          push_en;
    logic [KW-1:0] push_k;
    logic [IW-1:0] push_idx;

    always_comb begin
        upper_half = r_baddr + (AW'(1) << (r_src - OW'(1)));
        free_ord   = r_tag_rd[OW-1:0];
        if (free_ord < OW'(MIN_ORDER)) free_ord = OW'(MIN_ORDER);
        if (free_ord > OW'(MAX_ORDER)) free_ord = OW'(MAX_ORDER);
        push_en  = 1'b0;
        push_k   = '0;
        push_idx = '0;
        if (r_state == S_SPLIT && r_src > r_ord) begin
            push_en  = 1'b1;
            push_k   = KW'(r_src - OW'(1) - OW'(MIN_ORDER));
            push_idx = upper_half[AW-1:MIN_ORDER];
        end else if (r_state == S_FREE && r_tag_rd[OW]) begin
            push_en  = 1'b1;
            push_k   = KW'(free_ord - OW'(MIN_ORDER));
            push_idx = r_baddr[AW-1:MIN_ORDER];
        end
    end

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    logic          link_re;
    logic [IW-1:0] link_raddr;
    logic          tag_re;
    logic          tag_we;
    logic [IW-1:0] tag_addr;
    logic [TW-1:0] tag_wdata;

    always_comb begin
        link_re    = (r_state == S_SRCH) && found;
        link_raddr = r_head[src_k];
        tag_re     = (r_state == S_DEC) && (r_op == bba_pkg::OP_FREE);
        tag_we     = 1'b0;
        tag_addr   = baddr_f[AW-1:MIN_ORDER];
        tag_wdata  = '0;
        if (r_clr_busy) begin
            tag_we   = 1'b1;
            tag_addr = r_clr_idx;
        end else if (r_state == S_SPLIT && r_src == r_ord) begin
            tag_we    = 1'b1;
            tag_addr  = r_baddr[AW-1:MIN_ORDER];
            tag_wdata = {1'b1, r_ord};
        end else if (r_state == S_FREE && r_tag_rd[OW]) begin
            tag_we    = 1'b1;
            tag_addr  = r_baddr[AW-1:MIN_ORDER];
            tag_wdata = {1'b0, r_tag_rd[OW-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            link_mem[push_idx] <= {r_nonempty[push_k], r_head[push_k]};
        end
        if (link_re) begin
            r_link_rd <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            tag_mem[tag_addr] <= tag_wdata;
        end
        if (tag_re) begin
            r_tag_rd <= tag_mem[tag_addr];
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr   <= bba_pkg::HDR_RESET;
            r_limit <= bba_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bba_pkg::CFG_HEADER_BYTES: r_hdr   <= i_cfg_data[bba_pkg::HDR_W-1:0];
                bba_pkg::CFG_HEAP_LIMIT:   r_limit <= i_cfg_data[bba_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // List heads: hold unless a push or a pop touches them
    // ------------------------------------------------------------------
    logic [KW-1:0] pop_k;
    assign pop_k = KW'(r_src - OW'(MIN_ORDER));

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_head[push_k] <= push_idx;
        end else if (r_state == S_POP) begin
            r_head[pop_k] <= r_link_rd[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
        end else if (push_en) begin
            r_nonempty[push_k] <= 1'b1;
        end else if (r_state == S_POP) begin
            r_nonempty[pop_k] <= r_link_rd[IW];
        end
    end

    // ------------------------------------------------------------------
    // Tag clearing sweep after reset
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + IW'(1);
            if (r_clr_idx == {IW{1'b1}}) r_clr_busy <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [32:0] res_sum;
    assign res_sum = 33'(r_baddr) + 33'(r_hdr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nfp   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op    <= i_op;
                        r_req   <= i_request_bytes;
                        r_ua    <= i_user_address;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_res_addr <= '0;
                    r_res_ord  <= '0;
                    if (r_op == bba_pkg::OP_ALLOC) begin
                        if (r_req == '0) begin
                            r_res_stat <= bba_pkg::ST_ZERO_SIZE;
                            r_state    <= S_DONE;
                        end else if (ord_c > OW'(MAX_ORDER)) begin
                            r_res_stat <= bba_pkg::ST_TOO_LARGE;
                            r_state    <= S_DONE;
                        end else begin
                            r_ord   <= (ord_c < OW'(MIN_ORDER)) ? OW'(MIN_ORDER) : ord_c;
                            r_state <= S_SRCH;
                        end
                    end else begin
                        r_baddr <= baddr_f;
                        if (r_ua == '0) begin
                            r_res_stat <= bba_pkg::ST_NULL_FREE;
                            r_state    <= S_DONE;
                        end else if (bad_free) begin
                            r_res_stat <= bba_pkg::ST_NOT_ALLOC;
                            r_state    <= S_DONE;
                        end else begin
                            r_state <= S_FREE;
                        end
                    end
                end
                S_SRCH: begin
                    if (found) begin
                        // pop: link read issued this cycle
                        r_src   <= OW'(src_k) + OW'(MIN_ORDER);
                        r_baddr <= AW'(r_head[src_k]) << MIN_ORDER;
                        r_state <= S_POP;
                    end else if (oom) begin
                        r_res_stat <= bba_pkg::ST_NO_MEMORY;
                        r_state    <= S_DONE;
                    end else begin
                        r_src   <= fresh_ord;
                        r_baddr <= AW'(r_nfp) << PAGE_ORDER;
                        r_nfp   <= end_pg[bba_pkg::LIMIT_W-1:0];
                        r_state <= S_SPLIT;
                    end
                end
                S_POP: begin
                    r_state <= S_SPLIT;
                end
                S_SPLIT: begin
                    if (r_src > r_ord) begin
                        r_src <= r_src - OW'(1);
                    end else begin
                        r_res_addr <= res_sum[FW-1:0];
                        r_res_stat <= bba_pkg::ST_OK;
                        r_res_ord  <= r_ord;
                        r_state    <= S_DONE;
                    end
                end
                S_FREE: begin
                    if (r_tag_rd[OW]) begin
                        r_res_stat <= bba_pkg::ST_OK;
                        r_res_ord  <= free_ord;
                    end else begin
                        r_res_stat <= bba_pkg::ST_NOT_ALLOC;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_oval || i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on completion, drop when taken
    // ------------------------------------------------------------------
    logic out_load;
    assign out_load = (r_state == S_DONE) && (!r_oval || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (out_load) begin
            r_oval <= 1'b1;
        end else if (i_ready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oaddr <= r_res_addr;
            r_ostat <= r_res_stat;
            r_oord  <= r_res_ord;
        end
    end

    assign o_ready          = (r_state == S_IDLE) && !r_clr_busy;
    assign o_valid          = r_oval;
    assign o_result_address = r_oaddr;
    assign o_status         = r_ostat;
    assign o_granted_order  = r_oord;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (r_state == S_IDLE))
        else $error("sequencer left idle during tag sweep");

    a_start_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !(i_valid && o_ready)) |=> (r_state == S_IDLE))
        else $error("sequencer started without an accepted item");

    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == bba_pkg::ST_OK) |->
            (o_granted_order >= OW'(MIN_ORDER) && o_granted_order <= OW'(MAX_ORDER)))
        else $error("granted order outside list range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != bba_pkg::ST_OK) |->
            (o_result_address == '0 && o_granted_order == '0))
        else $error("failed item carries address or order");

endmodule
`default_nettype wire
